// File: src/csmq_pkg.sv
// Package with shared widths, codes and payload types of the cube shadow map query block.
package csmq_pkg;

  // Default cube face edge length in cells.
  localparam int MAP_SIZE_DEF = 128;

  // Number of cube faces.
  localparam int FACES = 6;

  // Coordinate, distance and bias widths of the external fields.
  localparam int CW_W   = 24;
  localparam int BIAS_W = 16;
  localparam int CELL_W = 14;

  // Direction component width, magnitude width and the width of u + m.
  localparam int DIR_W  = CW_W + 1;
  localparam int MAG_W  = CW_W + 1;
  localparam int NSUM_W = MAG_W + 1;

  // Square and squared length widths.
  localparam int SQ_W  = 2 * MAG_W;
  localparam int D2_W  = SQ_W + 2;

  // Item operation codes.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LIGHT_X = 2'd0,
    REG_LIGHT_Y = 2'd1,
    REG_LIGHT_Z = 2'd2,
    REG_BIAS    = 2'd3
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam logic [CW_W-1:0]   LIGHT_X_RST = 24'd65536;
  localparam logic [CW_W-1:0]   LIGHT_Y_RST = 24'd32000;
  localparam logic [CW_W-1:0]   LIGHT_Z_RST = 24'd65536;
  localparam logic [BIAS_W-1:0] BIAS_RST    = 16'd1792;

  // Fields of one item that travel down the pipeline.
  typedef struct packed {
    op_e               op;
    logic [2:0]        face;
    logic [CELL_W-1:0] cell_idx;
    logic [CW_W-1:0]   value;
  } item_t;

  // Sideband that rides along the coordinate dividers.
  typedef struct packed {
    item_t           it;
    logic            no_dir;
    logic [D2_W-1:0] dist2;
  } mid_t;

endpackage

// File: src/csmq_if.sv
// Valid/ready channel interfaces for the input and result words.
interface csmq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [2:0]                          face;
  logic [csmq_pkg::CELL_W-1:0]         cell_req;
  logic [csmq_pkg::CW_W-1:0]           map_value;
  logic signed [csmq_pkg::CW_W-1:0]    point_x;
  logic signed [csmq_pkg::CW_W-1:0]    point_y;
  logic signed [csmq_pkg::CW_W-1:0]    point_z;

  modport source (output valid, operation, face, cell_req, map_value, point_x, point_y,
                  point_z, input ready);
  modport sink   (input valid, operation, face, cell_req, map_value, point_x, point_y,
                  point_z, output ready);
endinterface

interface csmq_out_if;
  logic valid;
  logic ready;
  logic shadowed;
  logic no_map;

  modport source (output valid, shadowed, no_map, input ready);
  modport sink   (input valid, shadowed, no_map, output ready);
endinterface

// File: src/csmq_ram.sv
// Generic single write port, single read port RAM with registered read data.
module csmq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/csmq_front.sv
// Front pipeline: direction, magnitudes, dominant axis, squared length and divider operands.
module csmq_front #(
  parameter int MAP_SIZE = csmq_pkg::MAP_SIZE_DEF,
  localparam int QW = $clog2(MAP_SIZE + 1),
  localparam int NW = csmq_pkg::NSUM_W + QW
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  csmq_pkg::item_t                     item_i,
  input  logic signed [csmq_pkg::CW_W-1:0]    point_x_i,
  input  logic signed [csmq_pkg::CW_W-1:0]    point_y_i,
  input  logic signed [csmq_pkg::CW_W-1:0]    point_z_i,
  input  logic signed [csmq_pkg::CW_W-1:0]    light_x_i,
  input  logic signed [csmq_pkg::CW_W-1:0]    light_y_i,
  input  logic signed [csmq_pkg::CW_W-1:0]    light_z_i,
  output logic                                valid_o,
  output csmq_pkg::mid_t                      mid_o,
  output logic [NW-1:0]                       num_o [2],
  output logic [csmq_pkg::NSUM_W-1:0]         den_o
);

  localparam int DW = csmq_pkg::DIR_W;
  localparam int MW = csmq_pkg::MAG_W;

  // Stage one: direction from the light to the point.
  logic                  v1_q;
  csmq_pkg::item_t       it1_q;
  logic signed [DW-1:0]  d1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q   <= item_i;
      d1_q[0] <= DW'(point_x_i) - DW'(light_x_i);
      d1_q[1] <= DW'(point_y_i) - DW'(light_y_i);
      d1_q[2] <= DW'(point_z_i) - DW'(light_z_i);
    end
  end

  // Stage two: component magnitudes.
  logic                  v2_q;
  csmq_pkg::item_t       it2_q;
  logic signed [DW-1:0]  d2_q [3];
  logic [MW-1:0]         a2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it2_q <= it1_q;
      for (int i = 0; i < 3; i++) begin
        d2_q[i] <= d1_q[i];
        a2_q[i] <= d1_q[i][DW-1] ? MW'(-d1_q[i]) : MW'(d1_q[i]);
      end
    end
  end

  // Stage three: squares, dominant axis (first strict maximum) and face.
  logic [1:0]            axis;
  logic [MW-1:0]         mag;
  logic [2:0]            face;
  logic signed [DW-1:0]  u_row, u_col;

  always_comb begin
    if ((a2_q[2] > a2_q[0]) && (a2_q[2] > a2_q[1])) begin
      axis = 2'd2;
    end else if (a2_q[1] > a2_q[0]) begin
      axis = 2'd1;
    end else begin
      axis = 2'd0;
    end
    mag   = a2_q[axis];
    face  = {axis, d2_q[axis][DW-1]};
    u_row = (axis == 2'd0) ? d2_q[1] : d2_q[0];
    u_col = (axis == 2'd2) ? d2_q[1] : d2_q[2];
  end

  // Queries carry the selected face from here on.
  csmq_pkg::item_t                 it3_d;

  always_comb begin
    it3_d = it2_q;
    if (it2_q.op == csmq_pkg::OP_QUERY) begin
      it3_d.face = face;
    end
  end

  logic                            v3_q;
  csmq_pkg::item_t                 it3_q;
  logic [csmq_pkg::SQ_W-1:0]       sq3_q [3];
  logic [MW-1:0]                   mag3_q;
  logic signed [DW-1:0]            ur3_q, uc3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it3_q <= it3_d;
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= csmq_pkg::SQ_W'(a2_q[i]) * csmq_pkg::SQ_W'(a2_q[i]);
      end
      mag3_q <= mag;
      ur3_q  <= u_row;
      uc3_q  <= u_col;
    end
  end

  // Stage four: squared length, scaled numerators and divisor.
  logic [csmq_pkg::NSUM_W-1:0] n_row, n_col;

  assign n_row = csmq_pkg::NSUM_W'($signed({ur3_q[DW-1], ur3_q}) +
                                   $signed({1'b0, mag3_q}));
  assign n_col = csmq_pkg::NSUM_W'($signed({uc3_q[DW-1], uc3_q}) +
                                   $signed({1'b0, mag3_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_o.it     <= it3_q;
      mid_o.no_dir <= (mag3_q == '0);
      mid_o.dist2  <= csmq_pkg::D2_W'(sq3_q[0]) + csmq_pkg::D2_W'(sq3_q[1]) +
                      csmq_pkg::D2_W'(sq3_q[2]);
      num_o[0]     <= NW'(n_row) * NW'(MAP_SIZE);
      num_o[1]     <= NW'(n_col) * NW'(MAP_SIZE);
      den_o        <= {mag3_q, 1'b0};
    end
  end

endmodule

// File: src/csmq_div.sv
// Pipelined restoring divider: two lanes share one divisor, one quotient bit per stage.
module csmq_div #(
  parameter int MAP_SIZE = csmq_pkg::MAP_SIZE_DEF,
  parameter int SBW      = 1,
  localparam int QW = $clog2(MAP_SIZE + 1),
  localparam int NW = csmq_pkg::NSUM_W + QW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [SBW-1:0]              sb_i,
  input  logic [NW-1:0]               num_i [2],
  input  logic [csmq_pkg::NSUM_W-1:0] den_i,
  output logic                        valid_o,
  output logic [SBW-1:0]              sb_o,
  output logic [QW-1:0]               quo_o [2]
);

  logic                        v_s   [QW+1];
  logic [SBW-1:0]              sb_s  [QW+1];
  logic [csmq_pkg::NSUM_W-1:0] den_s [QW+1];
  logic [NW-1:0]               rem_s [QW+1][2];
  logic [QW-1:0]               quo_s [QW+1][2];

  // Stage inputs.
  assign v_s[0]      = valid_i;
  assign sb_s[0]     = sb_i;
  assign den_s[0]    = den_i;
  assign rem_s[0][0] = num_i[0];
  assign rem_s[0][1] = num_i[1];
  assign quo_s[0][0] = '0;
  assign quo_s[0][1] = '0;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int BIT = QW - 1 - s;
    logic [NW-1:0] dsh;

    assign dsh = NW'(den_s[s]) << BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[s+1] <= 1'b0;
      end else if (en_i) begin
        v_s[s+1] <= v_s[s];
      end
    end

    // One trial subtraction per lane decides one quotient bit.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_s[s+1]  <= sb_s[s];
        den_s[s+1] <= den_s[s];
        for (int l = 0; l < 2; l++) begin
          if (rem_s[s][l] >= dsh) begin
            rem_s[s+1][l] <= rem_s[s][l] - dsh;
            quo_s[s+1][l] <= quo_s[s][l] | (QW'(1) << BIT);
          end else begin
            rem_s[s+1][l] <= rem_s[s][l];
            quo_s[s+1][l] <= quo_s[s][l];
          end
        end
      end
    end
  end

  assign valid_o  = v_s[QW];
  assign sb_o     = sb_s[QW];
  assign quo_o[0] = quo_s[QW][0];
  assign quo_o[1] = quo_s[QW][1];

endmodule

// File: src/csmq_back.sv
// Back pipeline: cell address, map memory access, face presence and the depth test.
module csmq_back #(
  parameter int MAP_SIZE = csmq_pkg::MAP_SIZE_DEF,
  localparam int QW = $clog2(MAP_SIZE + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  csmq_pkg::mid_t                mid_i,
  input  logic [QW-1:0]                 quo_i [2],
  input  logic [csmq_pkg::BIAS_W-1:0]   bias_i,
  output logic                          valid_o,
  output logic                          shadowed_o,
  output logic                          no_map_o
);

  localparam int CW    = $clog2(MAP_SIZE);
  localparam int CPF   = MAP_SIZE * MAP_SIZE;
  localparam int DEPTH = csmq_pkg::FACES * CPF;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = csmq_pkg::CW_W;

  // Clamp the coordinates and form the cell address.
  logic [CW-1:0] row, col;
  logic [AW-1:0] raddr, waddr;
  logic          load_ok, we;

  assign row = (quo_i[0] > QW'(MAP_SIZE - 1)) ? CW'(MAP_SIZE - 1) : CW'(quo_i[0]);
  assign col = (quo_i[1] > QW'(MAP_SIZE - 1)) ? CW'(MAP_SIZE - 1) : CW'(quo_i[1]);

  assign raddr = AW'(mid_i.it.face) * AW'(CPF) + AW'(row) * AW'(MAP_SIZE) + AW'(col);
  assign waddr = AW'(mid_i.it.face) * AW'(CPF) + AW'(mid_i.it.cell_idx);

  assign load_ok = (mid_i.it.face < 3'(csmq_pkg::FACES)) &&
                   (32'(mid_i.it.cell_idx) < 32'(CPF));
  assign we = en_i && valid_i && (mid_i.it.op == csmq_pkg::OP_LOAD) && load_ok;

  logic [VW-1:0] rdata;

  csmq_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (mid_i.it.value),
    .re_i    (en_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Face presence flags, set by nonzero loads in item order.
  logic [csmq_pkg::FACES-1:0] present_q;
  logic                       face_here;

  assign face_here = (mid_i.it.face < 3'(csmq_pkg::FACES)) &&
                     present_q[mid_i.it.face];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (we && (mid_i.it.value != '0)) begin
      present_q[mid_i.it.face] <= 1'b1;
    end
  end

  // Stage one: memory read in flight.
  logic                  v1_q;
  logic                  q1_q;
  logic                  nm1_q;
  logic [csmq_pkg::D2_W-1:0] d2_1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q   <= (mid_i.it.op == csmq_pkg::OP_QUERY);
      nm1_q  <= mid_i.no_dir || !face_here;
      d2_1_q <= mid_i.dist2;
    end
  end

  // Stage two: square of the biased stored distance.
  logic                      v2_q, q2_q, nm2_q, nz2_q;
  logic [csmq_pkg::D2_W-1:0] d2_2_q;
  logic [csmq_pkg::SQ_W-1:0] sq2_q;
  logic [csmq_pkg::MAG_W-1:0] sum;

  assign sum = csmq_pkg::MAG_W'(rdata) + csmq_pkg::MAG_W'(bias_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q2_q   <= q1_q;
      nm2_q  <= nm1_q;
      nz2_q  <= (rdata != '0);
      d2_2_q <= d2_1_q;
      sq2_q  <= csmq_pkg::SQ_W'(sum) * csmq_pkg::SQ_W'(sum);
    end
  end

  // Stage three: result register; loads leave no result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q && q2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      no_map_o   <= nm2_q;
      shadowed_o <= !nm2_q && nz2_q && (csmq_pkg::D2_W'(sq2_q) < d2_2_q);
    end
  end

endmodule

// File: src/cube_shadow_map_query_top.sv
// Top level of the cube shadow map query block.
//
//   channel  dir  words                       handshake
//   in_i     in   load or query               valid/ready
//   out_o    out  shadowed, no_map per query  valid/ready
//   cfg      in   light x/y/z, bias           write enable, no wait
//
// One word is taken per cycle unless a result waits unread at the output. A
// query result passes four front stages, one divider stage per quotient bit,
// then memory read, bias square and the result register. Reset clears valid
// bits and face flags and loads the configuration reset values; the map memory
// is not cleared. The whole pipeline holds while a result waits at the output.
module cube_shadow_map_query_top #(
  parameter int MAP_SIZE = csmq_pkg::MAP_SIZE_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  csmq_in_if.sink                   in_i,
  csmq_out_if.source                out_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [csmq_pkg::CW_W-1:0] cfg_data_i
);

  localparam int QW = $clog2(MAP_SIZE + 1);
  localparam int NW = csmq_pkg::NSUM_W + QW;
  localparam int SBW = $bits(csmq_pkg::mid_t);

  // Configuration registers.
  logic [csmq_pkg::CW_W-1:0]   light_x_q, light_y_q, light_z_q;
  logic [csmq_pkg::BIAS_W-1:0] bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q <= csmq_pkg::LIGHT_X_RST;
      light_y_q <= csmq_pkg::LIGHT_Y_RST;
      light_z_q <= csmq_pkg::LIGHT_Z_RST;
      bias_q    <= csmq_pkg::BIAS_RST;
    end else if (cfg_we_i) begin
      unique case (csmq_pkg::cfg_reg_e'(cfg_idx_i))
        csmq_pkg::REG_LIGHT_X: light_x_q <= cfg_data_i;
        csmq_pkg::REG_LIGHT_Y: light_y_q <= cfg_data_i;
        csmq_pkg::REG_LIGHT_Z: light_z_q <= cfg_data_i;
        csmq_pkg::REG_BIAS:    bias_q    <= cfg_data_i[csmq_pkg::BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves unless a result waits unread.
  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  csmq_pkg::item_t item;
  assign item.op       = csmq_pkg::op_e'(in_i.operation);
  assign item.face     = in_i.face;
  assign item.cell_idx = in_i.cell_req;
  assign item.value    = in_i.map_value;

  logic                        f_valid;
  csmq_pkg::mid_t              f_mid;
  logic [NW-1:0]               f_num [2];
  logic [csmq_pkg::NSUM_W-1:0] f_den;

  csmq_front #(.MAP_SIZE(MAP_SIZE)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_i.valid),
    .item_i    (item),
    .point_x_i (in_i.point_x),
    .point_y_i (in_i.point_y),
    .point_z_i (in_i.point_z),
    .light_x_i ($signed(light_x_q)),
    .light_y_i ($signed(light_y_q)),
    .light_z_i ($signed(light_z_q)),
    .valid_o   (f_valid),
    .mid_o     (f_mid),
    .num_o     (f_num),
    .den_o     (f_den)
  );

  logic           d_valid;
  logic [SBW-1:0] d_sb;
  logic [QW-1:0]  d_quo [2];
  csmq_pkg::mid_t d_mid;

  csmq_div #(.MAP_SIZE(MAP_SIZE), .SBW(SBW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .sb_i    (f_mid),
    .num_i   (f_num),
    .den_i   (f_den),
    .valid_o (d_valid),
    .sb_o    (d_sb),
    .quo_o   (d_quo)
  );

  assign d_mid = csmq_pkg::mid_t'(d_sb);

  csmq_back #(.MAP_SIZE(MAP_SIZE)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (d_valid),
    .mid_i      (d_mid),
    .quo_i      (d_quo),
    .bias_i     (bias_q),
    .valid_o    (out_o.valid),
    .shadowed_o (out_o.shadowed),
    .no_map_o   (out_o.no_map)
  );

endmodule

// File: src/csmq_checker.sv
// Port checker for the cube shadow map query block and its bind.
module csmq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic shadowed_i,
  input logic no_map_i
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(shadowed_i) && $stable(no_map_i))
    else $error("result word changed while stalled");

  // A missing map never reports shadow.
  a_no_map_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && no_map_i |-> !shadowed_i)
    else $error("shadowed set together with no_map");

  // With the output empty the pipeline takes a word.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // A waiting result holds the whole pipeline.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

endmodule

bind cube_shadow_map_query_top csmq_checker u_csmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .shadowed_i  (out_o.shadowed),
  .no_map_i    (out_o.no_map)
);

// File: bench/cube_shadow_map_query_top_tb.sv
// Self-checking testbench of the cube shadow map query block with a built-in shadow predictor.
`timescale 1ns / 1ps

module cube_shadow_map_query_top_tb;

  localparam int MSIZE = csmq_pkg::MAP_SIZE_DEF;
  localparam int CELLS = MSIZE * MSIZE;
  localparam int DRAIN = 40;
  localparam int IDLE_LIMIT = 20000;

  // One input word as the driver sees it.
  typedef struct packed {
    csmq_pkg::op_e    op;
    logic [2:0]       face;
    logic [13:0]      cell_idx;
    logic [23:0]      val;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
  } word_t;

  // One query verdict.
  typedef struct packed {
    logic shadowed;
    logic no_map;
  } verdict_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [csmq_pkg::CW_W-1:0] cfg_data_i;

  csmq_in_if  in_if ();
  csmq_out_if out_if ();

  cube_shadow_map_query_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if.sink),
    .out_o      (out_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  word_t    word_queue[$];
  verdict_t pending_verdicts[$];

  // Predictor state, updated on accepted words and register writes.
  logic [23:0] shadow_map[int];
  logic [5:0]  pred_present;
  logic signed [23:0] pred_lx, pred_ly, pred_lz;
  logic [15:0] pred_bias;

  // Stimulus-side view, used to avoid reading cells that were never written.
  bit          gen_written[0:6*CELLS-1];
  logic [5:0]  gen_present;
  logic signed [23:0] gen_lx, gen_ly, gen_lz;
  logic [15:0] gen_bias;

  int  errors;
  int  idle_cycles;
  bit  in_taken;
  int  burst_left;
  int  gap_left;
  int  ready_pct;
  int  ready_phase;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint cell_coord(longint u, longint m);
    longint c;
    c = ((u + m) * MSIZE) / (2 * m);
    if (c > MSIZE - 1) c = MSIZE - 1;
    return c;
  endfunction

  // Picks the face and cell that a direction selects; face is -1 for zero direction.
  function automatic void locate_cell(input longint dx, input longint dy, input longint dz,
                                      output int fc, output int cl, output longint dist2);
    longint d[3];
    longint a;
    longint mag;
    longint u;
    longint v;
    int ax;
    d[0] = dx; d[1] = dy; d[2] = dz;
    mag = 0; ax = -1; dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      a = (d[i] < 0) ? -d[i] : d[i];
      dist2 += a * a;
      if (a > mag) begin
        mag = a;
        ax = i;
      end
    end
    fc = -1;
    cl = 0;
    if (ax >= 0) begin
      fc = ax * 2 + ((d[ax] > 0) ? 0 : 1);
      u = (ax == 0) ? d[1] : d[0];
      v = (ax == 2) ? d[1] : d[2];
      cl = int'(cell_coord(u, mag) * MSIZE + cell_coord(v, mag));
    end
  endfunction

  // Applies one accepted word to the predictor and queues the verdict it causes.
  function automatic void predict_shadow(word_t w);
    int fc;
    int cl;
    longint dist2;
    longint m;
    longint s;
    verdict_t vd;
    if (w.op == csmq_pkg::OP_LOAD) begin
      if (w.face < 6 && w.cell_idx < CELLS) begin
        shadow_map[w.face * CELLS + w.cell_idx] = w.val;
        if (w.val != 0) pred_present[w.face] = 1'b1;
      end
    end else begin
      locate_cell(longint'(w.px) - longint'(pred_lx), longint'(w.py) - longint'(pred_ly),
                  longint'(w.pz) - longint'(pred_lz), fc, cl, dist2);
      vd = '{shadowed: 1'b0, no_map: 1'b1};
      if (fc >= 0 && pred_present[fc]) begin
        m = shadow_map.exists(fc * CELLS + cl) ? longint'(shadow_map[fc * CELLS + cl]) : 0;
        s = m + longint'(pred_bias);
        vd.no_map = 1'b0;
        vd.shadowed = (m != 0) && (s * s < dist2);
      end
      pending_verdicts.push_back(vd);
    end
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Queues a load and records it on the stimulus side.
  function automatic void push_load(int fc, int cl, logic [23:0] val);
    word_t w;
    w = '0;
    w.op = csmq_pkg::OP_LOAD;
    w.face = fc[2:0];
    w.cell_idx = cl[13:0];
    w.val = val;
    w.px = 24'($urandom); w.py = 24'($urandom); w.pz = 24'($urandom);
    word_queue.push_back(w);
    if (fc < 6) begin
      gen_written[fc * CELLS + cl] = 1'b1;
      if (val != 0) gen_present[fc] = 1'b1;
    end
  endfunction

  // Queues a query after loading its unwritten cell on a live face, or randomly if allow_fill.
  function automatic void push_query(longint px, longint py, longint pz, bit allow_fill);
    word_t w;
    int fc;
    int cl;
    longint dist2;
    longint dist_est;
    longint val;
    locate_cell(px - longint'(gen_lx), py - longint'(gen_ly), pz - longint'(gen_lz),
                fc, cl, dist2);
    if (fc >= 0 && !gen_written[fc * CELLS + cl] &&
        (gen_present[fc] || (allow_fill && $urandom_range(0, 1)))) begin
      dist_est = longint'($sqrt(real'(dist2)));
      val = dist_est - longint'(gen_bias)
            + longint'($urandom_range(0, 2 * (dist_est / 8) + 4)) - (dist_est / 8) - 2;
      if (val < 1) val = 1;
      if (val > 24'hFFFFFF) val = 24'hFFFFFF;
      if ($urandom_range(0, 9) == 0) val = 0;
      push_load(fc, cl, val[23:0]);
    end
    w = '0;
    w.op = csmq_pkg::OP_QUERY;
    w.face = 3'($urandom);
    w.cell_idx = 14'($urandom);
    w.val = 24'($urandom);
    w.px = px[23:0]; w.py = py[23:0]; w.pz = pz[23:0];
    word_queue.push_back(w);
  endfunction

  // Query near the light, at a random scale.
  function automatic void push_near_query();
    int sc;
    sc = $urandom_range(2, 16);
    push_query(sat24(longint'(gen_lx) + $signed($urandom_range(0, 2 << sc)) - (1 << sc)),
               sat24(longint'(gen_ly) + $signed($urandom_range(0, 2 << sc)) - (1 << sc)),
               sat24(longint'(gen_lz) + $signed($urandom_range(0, 2 << sc)) - (1 << sc)), 1'b1);
  endfunction

  task automatic write_reg(csmq_pkg::cfg_reg_e idx, logic [23:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_light(logic [23:0] lx, logic [23:0] ly, logic [23:0] lz, logic [23:0] b);
    write_reg(csmq_pkg::REG_LIGHT_X, lx);
    write_reg(csmq_pkg::REG_LIGHT_Y, ly);
    write_reg(csmq_pkg::REG_LIGHT_Z, lz);
    write_reg(csmq_pkg::REG_BIAS, b);
    gen_lx = lx; gen_ly = ly; gen_lz = lz; gen_bias = b[15:0];
  endtask

  // Waits until every word is in and every verdict is out, then lets loads settle.
  task automatic wait_drained();
    while (word_queue.size() != 0 || in_if.valid || pending_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 60) push_near_query();
      else if (k < 75) push_query(longint'($signed(24'($urandom))),
                                  longint'($signed(24'($urandom))),
                                  longint'($signed(24'($urandom))), 1'b1);
      else if (k < 90) begin
        // Reload a cell with a random value, now and then an ignored face.
        push_load($urandom_range(0, 7), $urandom_range(0, CELLS - 1),
                  ($urandom_range(0, 7) == 0) ? 24'd0 : 24'($urandom));
      end else begin
        // Exact tie between two axes: the first one wins.
        k = $urandom_range(1, 4000);
        push_query(sat24(longint'(gen_lx) + k), sat24(longint'(gen_ly) - k),
                   sat24(longint'(gen_lz) + longint'($urandom_range(0, k - 1))), 1'b1);
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    logic [23:0] big;
    errors = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = csmq_pkg::REG_LIGHT_X;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.operation = csmq_pkg::OP_LOAD;
    in_if.face = '0;
    in_if.cell_req = '0;
    in_if.map_value = '0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.point_z = '0;
    out_if.ready = 1'b0;
    gen_present = '0;
    gen_lx = csmq_pkg::LIGHT_X_RST; gen_ly = csmq_pkg::LIGHT_Y_RST;
    gen_lz = csmq_pkg::LIGHT_Z_RST; gen_bias = csmq_pkg::BIAS_RST;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with reset settings.
    push_query(gen_lx, gen_ly, gen_lz, 1'b0);                  // zero direction
    push_query(gen_lx + 5000, gen_ly, gen_lz, 1'b0);           // face absent
    push_load(6, 10, 24'h123456);                              // ignored faces
    push_load(7, 16383, 24'hFFFFFF);
    push_load(2, 0, 24'd0);                                    // zero load
    push_query(gen_lx, gen_ly + 800, gen_lz, 1'b0);            // still absent
    push_load(0, 16383, 24'hFFFFFF);
    push_load(1, 0, 24'd1);
    push_query(gen_lx + 5000, gen_ly, gen_lz, 1'b1);
    push_query(gen_lx - 5000, gen_ly + 4999, gen_lz - 4999, 1'b1);
    push_query(gen_lx + 300, gen_ly + 300, gen_lz + 300, 1'b1);  // three-way tie
    push_query(8388607, 8388607, 8388607, 1'b1);
    push_query(-8388608, -8388608, -8388608, 1'b1);
    push_query(-8388608, 8388607, 0, 1'b1);
    for (int f = 0; f < 6; f++) push_load(f, $urandom_range(0, CELLS - 1), 24'($urandom));
    push_query(gen_lx, gen_ly, gen_lz - 9000, 1'b1);
    push_query(gen_lx, gen_ly - 9000, gen_lz, 1'b1);
    random_phase(60);
    wait_drained();

    // Extreme and random register settings.
    set_light(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h000000);
    push_query(-8388608, -8388608, -8388608, 1'b1);
    push_query(8388607, 8388607, 8388607, 1'b1);
    random_phase(50);
    wait_drained();
    set_light(24'h800000, 24'h800000, 24'h800000, 24'hFFFFFF);
    push_query(8388607, -8388608, -8388608, 1'b1);
    random_phase(50);
    wait_drained();
    big = $urandom;
    set_light(24'($urandom), 24'($urandom), 24'($urandom), {big[23:16], 16'hFFFF});
    random_phase(40);
    wait_drained();
    set_light(24'($urandom_range(0, 65535)) - 24'd32768, 24'd0, 24'd256,
              24'($urandom_range(0, 4096)));
    random_phase(110);
    wait_drained();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Sampling at the rising edge: acceptance, prediction, verdict checks, watchdog.
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v;
    if (!rst_ni) begin
      in_taken = 1'b0;
      idle_cycles = 0;
      shadow_map.delete();
      pred_present = '0;
      pred_lx = csmq_pkg::LIGHT_X_RST; pred_ly = csmq_pkg::LIGHT_Y_RST;
      pred_lz = csmq_pkg::LIGHT_Z_RST;
      pred_bias = csmq_pkg::BIAS_RST;
    end else begin
      in_taken = in_if.valid && in_if.ready;
      if (cfg_we_i) begin
        case (csmq_pkg::cfg_reg_e'(cfg_idx_i))
          csmq_pkg::REG_LIGHT_X: pred_lx = cfg_data_i;
          csmq_pkg::REG_LIGHT_Y: pred_ly = cfg_data_i;
          csmq_pkg::REG_LIGHT_Z: pred_lz = cfg_data_i;
          csmq_pkg::REG_BIAS:    pred_bias = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_taken)
        predict_shadow('{op: csmq_pkg::op_e'(in_if.operation), face: in_if.face,
                         cell_idx: in_if.cell_req, val: in_if.map_value,
                         px: in_if.point_x, py: in_if.point_y, pz: in_if.point_z});
      if (out_if.valid && out_if.ready) begin
        if (pending_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected verdict word: shadowed=%0b no_map=%0b",
                                     out_if.shadowed, out_if.no_map);
        end else begin
          exp_v = pending_verdicts.pop_front();
          if (out_if.shadowed !== exp_v.shadowed || out_if.no_map !== exp_v.no_map) begin
            errors++;
            if (errors <= 10)
              $display("Verdict mismatch: expected shadowed=%0b no_map=%0b, got %0b %0b",
                       exp_v.shadowed, exp_v.no_map, out_if.shadowed, out_if.no_map);
          end
        end
      end
      if (in_taken || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    word_t w;
    if (!rst_ni) begin
      burst_left = 1;
      gap_left = 0;
    end else if (!in_if.valid || in_taken) begin
      if (gap_left > 0 || word_queue.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_if.valid <= 1'b0;
      end else begin
        w = word_queue.pop_front();
        in_if.valid <= 1'b1;
        in_if.operation <= w.op;
        in_if.face <= w.face;
        in_if.cell_req <= w.cell_idx;
        in_if.map_value <= w.val;
        in_if.point_x <= w.px;
        in_if.point_y <= w.py;
        in_if.point_z <= w.pz;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: ready is random, with a probability that is redrawn periodically.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      ready_phase = 0;
      ready_pct = 100;
    end else begin
      ready_phase++;
      if (ready_phase % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 70;
          2: ready_pct = 30;
          default: ready_pct = 5;
        endcase
      end
      out_if.ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

endmodule
